// File: rtl/core/brf_pkg.sv
// Shared types and constants for the burst byte ring FIFO.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package brf_pkg;

    localparam int BANKS  = 8;
    localparam int BYTE_W = 8;

    typedef enum logic [1:0] {
        ACT_PUSH = 2'd0,
        ACT_POP  = 2'd1,
        ACT_PEEK = 2'd2
    } action_t;

    // Result-side control for one request, passed from the control stage
    // to the output stage alongside the bank read data.
    typedef struct packed {
        logic [3:0]  moved;
        logic        rejected;
        logic        is_read;
        logic [2:0]  base_bank;
        logic [10:0] fill;
    } result_info_t;

endpackage

`default_nettype wire

// File: rtl/core/brf_bank.sv
// One byte-wide bank of the ring store; holds every eighth byte of the ring.
// Depends on brf_pkg for the bank count and byte width.
`timescale 1ns / 1ps
`default_nettype none

module brf_bank #(
    parameter int ROWS = 128,
    parameter int BANK = 0
) (
    input  wire logic                                 clk,
    input  wire logic                                 we,
    input  wire logic [$clog2(ROWS)+2:0]              wr_ptr,
    input  wire logic [3:0]                           wr_len,
    input  wire logic [brf_pkg::BANKS*brf_pkg::BYTE_W-1:0] wr_data,
    input  wire logic                                 re,
    input  wire logic [$clog2(ROWS)+2:0]              rd_ptr,
    output logic [brf_pkg::BYTE_W-1:0]                rdata
);

    localparam int RW = $clog2(ROWS);

    logic [brf_pkg::BYTE_W-1:0] mem [ROWS];

    logic [2:0]    wr_ofs;
    logic [RW-1:0] wr_row;
    logic          wr_en;
    logic [RW-1:0] rd_row;

    // Row of this bank for a burst starting at ptr: banks below the start
    // bank belong to the next row.
    function automatic logic [RW-1:0] bank_row(input logic [RW+2:0] ptr);
        logic [RW-1:0] base;
        base = ptr[RW+2:3];
        if (3'(BANK) >= ptr[2:0]) begin
            return base;
        end
        if (base == RW'(ROWS - 1)) begin
            return '0;
        end
        return base + RW'(1);
    endfunction

    always_comb
    begin
        wr_ofs = 3'(BANK) - wr_ptr[2:0];
        wr_row = bank_row(wr_ptr);
        wr_en  = we && ({1'b0, wr_ofs} < wr_len);
        rd_row = bank_row(rd_ptr);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem[wr_row] <= wr_data[wr_ofs*brf_pkg::BYTE_W +: brf_pkg::BYTE_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (re) begin
            rdata <= mem[rd_row];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/brf_ctrl.sv
// Request decision, ring pointers, fill count and capacity register.
// Depends on brf_pkg for the action codes and the result info struct.
`timescale 1ns / 1ps
`default_nettype none

module brf_ctrl #(
    parameter int DEPTH     = 1024,
    parameter int MAX_BURST = 8,
    parameter int ROWS      = 128
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_write,
    input  wire logic [10:0]               cfg_data,
    input  wire logic                      accept,
    input  wire logic [1:0]                action,
    input  wire logic [3:0]                length,
    output logic                           push_go,
    output logic [$clog2(ROWS)+2:0]        wr_ptr,
    output logic [$clog2(ROWS)+2:0]        rd_ptr,
    output brf_pkg::result_info_t          info
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int PW   = $clog2(ROWS) + 3;
    localparam int VW   = (CW > 11) ? CW : 11;
    localparam int RING = ROWS * brf_pkg::BANKS;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] cap_reg, cap_next;
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    brf_pkg::result_info_t info_reg, info_next;

    logic          len_ok;
    logic          room_ok;
    logic          avail_ok;
    logic [VW-1:0] cfg_ext;
    logic          rejected;
    logic          is_read;
    logic          pop_go;

    function automatic logic [PW-1:0] ptr_add(input logic [PW-1:0] ptr, input logic [3:0] n);
        logic [PW:0] sum;
        sum = {1'b0, ptr} + (PW+1)'(n);
        if (sum >= (PW+1)'(RING)) begin
            sum = sum - (PW+1)'(RING);
        end
        return sum[PW-1:0];
    endfunction

    always_comb
    begin
        len_ok   = length <= 4'(MAX_BURST);
        room_ok  = ((CW+1)'(count_reg) + (CW+1)'(length)) <= (CW+1)'(cap_reg);
        avail_ok = CW'(length) <= count_reg;
        rejected = 1'b1;
        is_read  = 1'b0;
        case (brf_pkg::action_t'(action))
            brf_pkg::ACT_PUSH: rejected = !(len_ok && room_ok);
            brf_pkg::ACT_POP:
            begin
                rejected = !(len_ok && avail_ok);
                is_read  = 1'b1;
            end
            brf_pkg::ACT_PEEK:
            begin
                rejected = !(len_ok && avail_ok);
                is_read  = 1'b1;
            end
            default: rejected = 1'b1;
        endcase
        push_go = accept && !rejected && (action == brf_pkg::ACT_PUSH);
        pop_go  = accept && !rejected && (action == brf_pkg::ACT_POP);

        cfg_ext = VW'(cfg_data);
        if (cfg_ext == '0) begin
            cap_next = CW'(1);
        end else if (cfg_ext > VW'(DEPTH)) begin
            cap_next = CW'(DEPTH);
        end else begin
            cap_next = CW'(cfg_ext);
        end

        count_next  = count_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (cfg_write) begin
            count_next  = '0;
            wr_ptr_next = '0;
            rd_ptr_next = '0;
        end else if (push_go) begin
            count_next  = count_reg + CW'(length);
            wr_ptr_next = ptr_add(wr_ptr_reg, length);
        end else if (pop_go) begin
            count_next  = count_reg - CW'(length);
            rd_ptr_next = ptr_add(rd_ptr_reg, length);
        end

        info_next.moved     = rejected ? 4'd0 : length;
        info_next.rejected  = rejected;
        info_next.is_read   = is_read && !rejected;
        info_next.base_bank = rd_ptr_reg[2:0];
        info_next.fill      = 11'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg  <= '0;
            cap_reg    <= CW'(DEPTH);
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            if (cfg_write) begin
                cap_reg <= cap_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            info_reg <= info_next;
        end
    end

    assign wr_ptr = wr_ptr_reg;
    assign rd_ptr = rd_ptr_reg;
    assign info   = info_reg;

endmodule

`default_nettype wire

// File: rtl/core/brf_out.sv
// Output stage: aligns bank read bytes into a burst and holds the result beat.
// Depends on brf_pkg for the result info struct and bank geometry.
`timescale 1ns / 1ps
`default_nettype none

module brf_out (
    input  wire logic                                         clk,
    input  wire logic                                         load,
    input  wire brf_pkg::result_info_t                        info,
    input  wire logic [brf_pkg::BANKS-1:0][brf_pkg::BYTE_W-1:0] bank_data,
    output logic [3:0]                                        moved,
    output logic                                              rejected,
    output logic [brf_pkg::BANKS*brf_pkg::BYTE_W-1:0]         read_data,
    output logic [10:0]                                       fill_level
);

    logic [3:0]  moved_reg;
    logic        rejected_reg;
    logic [10:0] fill_reg;
    logic [brf_pkg::BANKS-1:0][brf_pkg::BYTE_W-1:0] data_reg, data_next;

    // Rotate so the oldest byte lands in lane 0; drop lanes past the burst.
    always_comb
    begin
        for (int i = 0; i < brf_pkg::BANKS; i++) begin
            if (info.is_read && (4'(i) < info.moved)) begin
                data_next[i] = bank_data[3'(info.base_bank + 3'(i))];
            end else begin
                data_next[i] = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            moved_reg    <= info.moved;
            rejected_reg <= info.rejected;
            fill_reg     <= info.fill;
            data_reg     <= data_next;
        end
    end

    assign moved      = moved_reg;
    assign rejected   = rejected_reg;
    assign read_data  = data_reg;
    assign fill_level = fill_reg;

endmodule

`default_nettype wire

// File: rtl/core/byte_ring_fifo_burst.sv
// Burst byte ring FIFO with a configurable capacity: top level.
// Uses brf_pkg, brf_ctrl, brf_bank (eight instances) and brf_out.
//
// Each input beat carries one request: push, pop or peek of up to eight
// bytes, all or nothing. Each request gives exactly one result beat with
// the bytes moved, a reject flag, the read bytes and the fill level after
// the request. A request is decided in the cycle it is accepted; the
// store is split into eight byte banks so a whole burst is written or
// read in that cycle. The result passes through the middle stage and is then
// held in the output register as the result beat until it is taken.
// One request per cycle is accepted as long as results are taken.
// When out_stall is high the result beat holds; one more request can
// complete into the middle stage, after which in_stall rises.
// Writing cfg_data with cfg_write sets the capacity (clamped to 1..DEPTH)
// and empties the queue; do so only while no request is in flight.
// Reset empties the queue and sets the capacity to DEPTH; the store
// itself is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module byte_ring_fifo_burst #(
    parameter int DEPTH     = 1024,
    parameter int MAX_BURST = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [10:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  action,
    input  wire logic [3:0]  length,
    input  wire logic [63:0] write_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [3:0]       moved,
    output logic             rejected,
    output logic [63:0]      read_data,
    output logic [10:0]      fill_level
);

    localparam int ROWS = (DEPTH + brf_pkg::BANKS - 1) / brf_pkg::BANKS;
    localparam int PW   = $clog2(ROWS) + 3;

    logic mid_valid_reg, mid_valid_next;
    logic out_valid_reg, out_valid_next;
    logic accept;
    logic out_load;
    logic push_go;
    logic [PW-1:0] wr_ptr;
    logic [PW-1:0] rd_ptr;
    brf_pkg::result_info_t info;
    logic [brf_pkg::BANKS-1:0][brf_pkg::BYTE_W-1:0] bank_data;

    always_comb
    begin
        out_load       = mid_valid_reg && (!out_valid_reg || !out_stall);
        in_stall       = mid_valid_reg && !out_load;
        accept         = in_valid && !in_stall;
        mid_valid_next = accept || (mid_valid_reg && !out_load);
        out_valid_next = out_load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            mid_valid_reg <= mid_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    brf_ctrl #(
        .DEPTH     (DEPTH),
        .MAX_BURST (MAX_BURST),
        .ROWS      (ROWS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .action    (action),
        .length    (length),
        .push_go   (push_go),
        .wr_ptr    (wr_ptr),
        .rd_ptr    (rd_ptr),
        .info      (info)
    );

    for (genvar b = 0; b < brf_pkg::BANKS; b++) begin : g_bank
        brf_bank #(
            .ROWS (ROWS),
            .BANK (b)
        ) u_bank (
            .clk     (clk),
            .we      (push_go),
            .wr_ptr  (wr_ptr),
            .wr_len  (length),
            .wr_data (write_data),
            .re      (accept),
            .rd_ptr  (rd_ptr),
            .rdata   (bank_data[b])
        );
    end

    brf_out u_out (
        .clk        (clk),
        .load       (out_load),
        .info       (info),
        .bank_data  (bank_data),
        .moved      (moved),
        .rejected   (rejected),
        .read_data  (read_data),
        .fill_level (fill_level)
    );

endmodule

`default_nettype wire

// File: test/tb.sv
// Self-checking bench for byte_ring_fifo_burst: push, pop and peek bursts.
// A scoreboard class mirrors the ring and checks each result beat in order.
// Depends on brf_pkg and the byte_ring_fifo_burst RTL only.
`timescale 1ns / 1ps

module tb;

    localparam int FIFO_DEPTH = 1024;
    localparam int BURST_MAX = 8;
    localparam int STALL_LIMIT = 5000;
    localparam logic [1:0] ACT_NONE = 2'd3;

    typedef struct {
        logic [3:0]  moved;
        logic        rejected;
        logic [63:0] rdata;
        logic [10:0] fill;
    } outcome_t;

    class ring_scoreboard;
        logic [7:0]  store [FIFO_DEPTH];
        int unsigned wr_pos;
        int unsigned rd_pos;
        int unsigned count;
        int unsigned cap;
        outcome_t    pending_outcomes [$];
        int unsigned mismatches;
        int unsigned results_seen;

        function new();
            cap = FIFO_DEPTH;
            mismatches = 0;
            results_seen = 0;
            clear_queue();
        endfunction

        function void clear_queue();
            wr_pos = 0;
            rd_pos = 0;
            count = 0;
        endfunction

        function void set_capacity(logic [10:0] value);
            cap = value;
            if (cap < 1)
                cap = 1;
            if (cap > FIFO_DEPTH)
                cap = FIFO_DEPTH;
            clear_queue();
        endfunction

        function int unsigned next_pos(int unsigned pos);
            return (pos + 1 >= cap) ? 0 : pos + 1;
        endfunction

        function void note_request(logic [1:0] act, logic [3:0] len, logic [63:0] wdata);
            outcome_t    o;
            int unsigned pos;
            o.moved = '0;
            o.rejected = 1'b0;
            o.rdata = '0;
            if (len > BURST_MAX || act == ACT_NONE) begin
                o.rejected = 1'b1;
            end
            else if (act == brf_pkg::ACT_PUSH) begin
                if (count + len > cap) begin
                    o.rejected = 1'b1;
                end
                else begin
                    for (int i = 0; i < len; i++) begin
                        store[wr_pos] = wdata[8*i +: 8];
                        wr_pos = next_pos(wr_pos);
                    end
                    count += len;
                    o.moved = len;
                end
            end
            else begin
                if (len > count) begin
                    o.rejected = 1'b1;
                end
                else begin
                    pos = rd_pos;
                    for (int i = 0; i < len; i++) begin
                        o.rdata[8*i +: 8] = store[pos];
                        pos = next_pos(pos);
                    end
                    if (act == brf_pkg::ACT_POP) begin
                        rd_pos = pos;
                        count -= len;
                    end
                    o.moved = len;
                end
            end
            o.fill = 11'(count);
            pending_outcomes.push_back(o);
        endfunction

        function void check_result(logic [3:0] moved_q, logic rej_q, logic [63:0] rdata_q,
                                   logic [10:0] fill_q);
            outcome_t o;
            results_seen++;
            if (pending_outcomes.size() == 0) begin
                if (mismatches < 10)
                    $display("result %0d: unexpected beat, moved %0d rejected %0d data %h fill %0d",
                             results_seen, moved_q, rej_q, rdata_q, fill_q);
                mismatches++;
                return;
            end
            o = pending_outcomes.pop_front();
            if (o.moved !== moved_q || o.rejected !== rej_q || o.rdata !== rdata_q ||
                o.fill !== fill_q) begin
                if (mismatches < 10) begin
                    $display("result %0d: expected moved %0d rejected %0d data %h fill %0d",
                             results_seen, o.moved, o.rejected, o.rdata, o.fill);
                    $display("result %0d: actual   moved %0d rejected %0d data %h fill %0d",
                             results_seen, moved_q, rej_q, rdata_q, fill_q);
                end
                mismatches++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [10:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  action;
    logic [3:0]  length;
    logic [63:0] write_data;
    logic        out_valid;
    logic        out_stall;
    logic [3:0]  moved;
    logic        rejected;
    logic [63:0] read_data;
    logic [10:0] fill_level;

    ring_scoreboard model;
    int unsigned    burst_left;
    int unsigned    idle_cycles;
    bit             filling;

    byte_ring_fifo_burst dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .length     (length),
        .write_data (write_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .moved      (moved),
        .rejected   (rejected),
        .read_data  (read_data),
        .fill_level (fill_level)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            model.check_result(moved, rejected, read_data, fill_level);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("byte_ring_fifo_burst: mismatch");
            $finish;
        end
    end

    initial
    begin
        int unsigned segment;
        int unsigned span;
        int unsigned odds;
        out_stall = 1'b0;
        segment = 0;
        forever begin
            segment++;
            if (segment % 9 == 3) begin
                // hold off long enough to back the block up into its input
                span = $urandom_range(40, 80);
                repeat (span) begin
                    @(negedge clk);
                    out_stall <= 1'b1;
                end
            end
            else if ($urandom_range(0, 2) == 0) begin
                span = $urandom_range(5, 40);
                repeat (span) begin
                    @(negedge clk);
                    out_stall <= 1'b0;
                end
            end
            else begin
                span = $urandom_range(10, 60);
                odds = $urandom_range(10, 70);
                repeat (span) begin
                    @(negedge clk);
                    out_stall <= ($urandom_range(0, 99) < odds);
                end
            end
        end
    end

    task automatic send_request(logic [1:0] act, logic [3:0] len, logic [63:0] wdata);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 24);
        end
        in_valid <= 1'b1;
        action <= act;
        length <= len;
        write_data <= wdata;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        model.note_request(act, len, wdata);
        burst_left--;
        @(negedge clk);
    endtask

    task automatic drain_results(int unsigned extra);
        in_valid <= 1'b0;
        while (model.pending_outcomes.size() != 0) @(negedge clk);
        repeat (extra) @(negedge clk);
        burst_left = 0;
    endtask

    task automatic write_capacity(logic [10:0] value);
        cfg_write <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        model.set_capacity(value);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic run_directed();
        send_request(brf_pkg::ACT_POP, 4'd1, 64'h0);
        send_request(brf_pkg::ACT_PEEK, 4'd1, 64'h0);
        send_request(brf_pkg::ACT_PUSH, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(brf_pkg::ACT_POP, 4'd0, 64'h0);
        send_request(brf_pkg::ACT_PEEK, 4'd0, 64'h0);
        send_request(brf_pkg::ACT_PUSH, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(brf_pkg::ACT_PUSH, 4'd5, 64'h1111_2222_3333_4444);
        send_request(brf_pkg::ACT_PUSH, 4'd4, 64'h0123_4567_89AB_CDEF);
        send_request(brf_pkg::ACT_PUSH, 4'd1, 64'h0);
        send_request(brf_pkg::ACT_PEEK, 4'd8, 64'h0);
        send_request(brf_pkg::ACT_POP, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(brf_pkg::ACT_PUSH, 4'd8, 64'h0123_4567_89AB_CDEF);
        send_request(brf_pkg::ACT_POP, 4'd4, 64'h0);
        send_request(brf_pkg::ACT_PEEK, 4'd8, 64'h0);
        send_request(brf_pkg::ACT_POP, 4'd9, 64'h0);
        send_request(brf_pkg::ACT_PUSH, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(ACT_NONE, 4'd2, 64'h0);
        send_request(ACT_NONE, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(brf_pkg::ACT_POP, 4'd8, 64'h0);
        send_request(brf_pkg::ACT_PEEK, 4'd0, 64'h0);
        send_request(brf_pkg::ACT_POP, 4'd1, 64'h0);
        send_request(brf_pkg::ACT_PUSH, 4'd3, 64'h0);
    endtask

    task automatic run_random(int unsigned items);
        logic [1:0]  act;
        logic [3:0]  len;
        logic [63:0] wdata;
        int unsigned bound;
        int unsigned pick;
        for (int n = 0; n < items; n++) begin
            wdata = {$urandom, $urandom};
            if (model.count == 0)
                filling = 1'b1;
            else if (model.cap - model.count < 3)
                filling = 1'b0;
            if ($urandom_range(0, 99) < 15) begin
                act = 2'($urandom_range(0, 3));
                len = 4'($urandom_range(0, 15));
            end
            else begin
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    act = brf_pkg::ACT_PEEK;
                else if ((pick < 80) == filling)
                    act = brf_pkg::ACT_PUSH;
                else
                    act = brf_pkg::ACT_POP;
                bound = (act == brf_pkg::ACT_PUSH) ? model.cap - model.count : model.count;
                if (bound > BURST_MAX)
                    bound = BURST_MAX;
                len = (bound > 0 && $urandom_range(0, 9) != 0) ? 4'($urandom_range(1, bound))
                                                                : 4'd0;
            end
            send_request(act, len, wdata);
        end
    endtask

    initial
    begin
        int unsigned phase_caps [8];
        int unsigned phase_items [8];
        model = new();
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        action = '0;
        length = '0;
        write_data = '0;
        burst_left = 0;
        idle_cycles = 0;
        filling = 1'b1;
        phase_caps = '{2047, 0, 1, 9, 16, 100, 1024, 0};
        phase_items = '{500, 120, 120, 200, 200, 250, 300, 200};
        phase_caps[7] = $urandom_range(2, 1023);
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        write_capacity(11'd12);
        run_directed();
        for (int p = 0; p < 8; p++) begin
            drain_results(4);
            write_capacity(11'(phase_caps[p]));
            run_random(phase_items[p]);
        end
        drain_results(8);
        if (model.mismatches == 0 && model.pending_outcomes.size() == 0)
            $display("byte_ring_fifo_burst: match");
        else
            $display("byte_ring_fifo_burst: mismatch");
        $finish;
    end

endmodule
